// ===== hdl/slex_pkg.sv =====
// Shared types, token codes and character constants for the script lexer.
`default_nettype none
package slex_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_TOK         = 3;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM, M_SLASH, M_LCOMM, M_CCOMM, M_CSTAR,
        M_EQ, M_LT, M_GT, M_BAR, M_AMP, M_Q1, M_Q2, M_BMSNL,
        M_SSTR, M_SESC, M_SDOL, M_MSTR, M_MESC, M_MDOL
    } lex_mode_t;

    localparam logic [5:0] TK_INVALID     = 6'd0;
    localparam logic [5:0] TK_NEWLINE     = 6'd2;
    localparam logic [5:0] TK_IDENT       = 6'd5;
    localparam logic [5:0] TK_NUMBER      = 6'd6;
    localparam logic [5:0] TK_BEGIN_STR   = 6'd7;
    localparam logic [5:0] TK_BEGIN_MSTR  = 6'd8;
    localparam logic [5:0] TK_STR_LIT     = 6'd9;
    localparam logic [5:0] TK_BEGIN_EMBED = 6'd10;
    localparam logic [5:0] TK_END_STR     = 6'd11;
    localparam logic [5:0] TK_LBRACE      = 6'd12;
    localparam logic [5:0] TK_RBRACE      = 6'd13;
    localparam logic [5:0] TK_LPAREN      = 6'd14;
    localparam logic [5:0] TK_RPAREN      = 6'd15;
    localparam logic [5:0] TK_SEMI        = 6'd19;
    localparam logic [5:0] TK_DOT         = 6'd20;
    localparam logic [5:0] TK_COMMA       = 6'd21;
    localparam logic [5:0] TK_ASSIGN      = 6'd22;
    localparam logic [5:0] TK_DIV_ASSIGN  = 6'd23;
    localparam logic [5:0] TK_LT          = 6'd24;
    localparam logic [5:0] TK_LE          = 6'd25;
    localparam logic [5:0] TK_GT          = 6'd26;
    localparam logic [5:0] TK_GE          = 6'd27;
    localparam logic [5:0] TK_EQ          = 6'd28;
    localparam logic [5:0] TK_PLUS        = 6'd29;
    localparam logic [5:0] TK_MINUS       = 6'd30;
    localparam logic [5:0] TK_STAR        = 6'd31;
    localparam logic [5:0] TK_SLASH       = 6'd32;
    localparam logic [5:0] TK_PERCENT     = 6'd33;
    localparam logic [5:0] TK_BANG        = 6'd34;
    localparam logic [5:0] TK_TILDE       = 6'd35;
    localparam logic [5:0] TK_BAR         = 6'd36;
    localparam logic [5:0] TK_OROR        = 6'd37;
    localparam logic [5:0] TK_AMP         = 6'd38;
    localparam logic [5:0] TK_ANDAND      = 6'd39;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_NEWLINE = 2'd2;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [1:0]  err;
    } tok_t;

    typedef struct packed {
        logic [1:0]              cnt;
        tok_t [MAX_TOK-1:0]      tok;
    } bundle_t;

    typedef struct packed {
        lex_mode_t  mode;
        logic       shc;
        logic [1:0] qr;
        logic       again;
        bundle_t    b;
    } sres_t;

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h3B:   k = TK_SEMI;
            8'h25:   k = TK_PERCENT;
            8'h21:   k = TK_BANG;
            8'h7E:   k = TK_TILDE;
            8'h7B:   k = TK_LBRACE;
            8'h7D:   k = TK_RBRACE;
            8'h28:   k = TK_LPAREN;
            8'h29:   k = TK_RPAREN;
            8'h2E:   k = TK_DOT;
            8'h2C:   k = TK_COMMA;
            8'h2B:   k = TK_PLUS;
            8'h2D:   k = TK_MINUS;
            8'h2A:   k = TK_STAR;
            default: k = TK_INVALID;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/slex_front.sv =====
// Lexer front end: per-byte state machine that classifies bytes and forms token bundles.
`default_nettype none
module slex_front #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             end_of_input,
    input  wire logic             in_string,
    input  wire logic             multiline,
    input  wire logic             emit_newlines,
    output slex_pkg::bundle_t     bundle,
    output logic                  push
);
    import slex_pkg::*;

    localparam int OB = OFFSET_BITS;

    lex_mode_t      mode_reg, mode_next;
    logic [OB-1:0]  pos_reg, pos_next;
    logic [OB-1:0]  tb_reg, tb_next;
    logic           shc_reg, shc_next;
    logic [1:0]     qr_reg, qr_next;

    logic [OB-1:0]  p, pe, b1, fb1;
    logic           again, idst, dig;
    logic [7:0]     second;
    logic [5:0]     dbl, sgl;
    bundle_t        bun;
    sres_t          sr;

    function automatic bundle_t add_tok(input bundle_t b, input logic [5:0] kind,
                                        input logic [OB-1:0] s, input logic [OB-1:0] e,
                                        input logic [1:0] err);
        bundle_t r;
        r = b;
        if (r.cnt < 2'(MAX_TOK)) begin
            r.tok[r.cnt] = {kind, 32'(s), 32'(e), err};
            r.cnt = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic sres_t str_byte(input logic [7:0] c, input logic [OB-1:0] pp,
                                       input lex_mode_t md, input logic shc,
                                       input logic [1:0] qr, input logic [OB-1:0] tb,
                                       input bundle_t b);
        sres_t r;
        logic ml;
        logic [OB-1:0] ppe, qs;
        ml = (md == M_MSTR);
        ppe = pp + 1'b1;
        qs = pp - OB'(2);
        r.mode = md;
        r.shc = shc;
        r.qr = qr;
        r.again = 1'b0;
        r.b = b;
        if (ml && qr != 2'd0 && c != CH_QUOTE) begin
            r.shc = 1'b1;
            r.qr = 2'd0;
        end
        if (c == CH_BSL) begin
            r.mode = ml ? M_MESC : M_SESC;
        end else if (c == CH_QUOTE) begin
            if (ml) begin
                r.qr = r.qr + 2'd1;
                if (r.qr == 2'd3) begin
                    if (r.shc) begin
                        r.b = add_tok(r.b, TK_STR_LIT, tb, qs, ERR_NONE);
                        r.b = add_tok(r.b, TK_END_STR, qs, ppe, ERR_NONE);
                    end else begin
                        r.b = add_tok(r.b, TK_END_STR, tb, ppe, ERR_NONE);
                    end
                    r.mode = M_IDLE;
                end
            end else if (r.shc) begin
                r.b = add_tok(r.b, TK_STR_LIT, tb, pp, ERR_NONE);
                r.mode = M_IDLE;
                r.again = 1'b1;
            end else begin
                r.b = add_tok(r.b, TK_END_STR, tb, ppe, ERR_NONE);
                r.mode = M_IDLE;
            end
        end else if (c == CH_DOLLAR) begin
            r.mode = ml ? M_MDOL : M_SDOL;
        end else if (c == CH_NL && !ml) begin
            r.b = add_tok(r.b, TK_INVALID, tb, ppe, ERR_NEWLINE);
            r.mode = M_IDLE;
        end else begin
            r.shc = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        mode_next = mode_reg;
        tb_next = tb_reg;
        shc_next = shc_reg;
        qr_next = qr_reg;
        again = 1'b0;
        bun = '0;
        sr = '0;
        second = CH_AMP;
        dbl = TK_ANDAND;
        sgl = TK_AMP;
        p = pos_reg;
        pe = pos_reg + 1'b1;
        b1 = tb_reg + 1'b1;
        idst = data_byte[7] || (data_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_USCORE});
        dig = data_byte inside {[8'h30:8'h39]};

        case (mode_reg)
            M_IDLE: again = 1'b1;
            M_IDENT, M_NUM: begin
                if (!(dig || (mode_reg == M_IDENT && idst))) begin
                    bun = add_tok(bun, (mode_reg == M_IDENT) ? TK_IDENT : TK_NUMBER,
                                  tb_reg, p, ERR_NONE);
                    mode_next = M_IDLE;
                    again = 1'b1;
                end
            end
            M_SLASH: begin
                if (data_byte == CH_SLASH) begin
                    mode_next = M_LCOMM;
                end else if (data_byte == CH_STAR) begin
                    mode_next = M_CCOMM;
                end else begin
                    mode_next = M_IDLE;
                    if (data_byte == CH_EQUAL) begin
                        bun = add_tok(bun, TK_DIV_ASSIGN, tb_reg, pe, ERR_NONE);
                    end else begin
                        bun = add_tok(bun, TK_SLASH, tb_reg, p, ERR_NONE);
                        again = 1'b1;
                    end
                end
            end
            M_LCOMM: begin
                if (data_byte == CH_NL) begin
                    mode_next = M_IDLE;
                    again = 1'b1;
                end
            end
            M_CCOMM: begin
                if (data_byte == CH_STAR) mode_next = M_CSTAR;
            end
            M_CSTAR: begin
                if (data_byte == CH_SLASH) mode_next = M_IDLE;
                else if (data_byte != CH_STAR) mode_next = M_CCOMM;
            end
            M_EQ, M_LT, M_GT, M_BAR, M_AMP: begin
                case (mode_reg)
                    M_EQ: begin
                        second = CH_EQUAL; dbl = TK_EQ; sgl = TK_ASSIGN;
                    end
                    M_LT: begin
                        second = CH_EQUAL; dbl = TK_LE; sgl = TK_LT;
                    end
                    M_GT: begin
                        second = CH_EQUAL; dbl = TK_GE; sgl = TK_GT;
                    end
                    M_BAR: begin
                        second = CH_BAR; dbl = TK_OROR; sgl = TK_BAR;
                    end
                    default: begin
                        second = CH_AMP; dbl = TK_ANDAND; sgl = TK_AMP;
                    end
                endcase
                mode_next = M_IDLE;
                if (data_byte == second) begin
                    bun = add_tok(bun, dbl, tb_reg, pe, ERR_NONE);
                end else begin
                    bun = add_tok(bun, sgl, tb_reg, p, ERR_NONE);
                    again = 1'b1;
                end
            end
            M_Q1: begin
                if (data_byte == CH_QUOTE) begin
                    mode_next = M_Q2;
                end else begin
                    bun = add_tok(bun, TK_BEGIN_STR, tb_reg, p, ERR_NONE);
                    mode_next = M_IDLE;
                    again = 1'b1;
                end
            end
            M_Q2: begin
                if (data_byte == CH_QUOTE) begin
                    mode_next = M_BMSNL;
                end else begin
                    bun = add_tok(bun, TK_BEGIN_STR, tb_reg, b1, ERR_NONE);
                    bun = add_tok(bun, TK_END_STR, b1, p, ERR_NONE);
                    mode_next = M_IDLE;
                    again = 1'b1;
                end
            end
            M_BMSNL: begin
                mode_next = M_IDLE;
                if (data_byte == CH_NL) begin
                    bun = add_tok(bun, TK_BEGIN_MSTR, tb_reg, pe, ERR_NONE);
                end else begin
                    bun = add_tok(bun, TK_BEGIN_MSTR, tb_reg, p, ERR_NONE);
                    again = 1'b1;
                end
            end
            M_SSTR, M_MSTR: begin
                sr = str_byte(data_byte, p, mode_reg, shc_reg, qr_reg, tb_reg, bun);
                mode_next = sr.mode; shc_next = sr.shc; qr_next = sr.qr;
                again = sr.again; bun = sr.b;
            end
            M_SESC, M_MESC: begin
                shc_next = 1'b1;
                mode_next = (mode_reg == M_MESC) ? M_MSTR : M_SSTR;
            end
            M_SDOL, M_MDOL: begin
                if (data_byte == CH_LBRACE) begin
                    if (shc_reg) begin
                        bun = add_tok(bun, TK_STR_LIT, tb_reg, p - 1'b1, ERR_NONE);
                        bun = add_tok(bun, TK_BEGIN_EMBED, p - 1'b1, pe, ERR_NONE);
                    end else begin
                        bun = add_tok(bun, TK_BEGIN_EMBED, tb_reg, pe, ERR_NONE);
                    end
                    mode_next = M_IDLE;
                end else begin
                    sr = str_byte(data_byte, p, (mode_reg == M_MDOL) ? M_MSTR : M_SSTR,
                                  1'b1, qr_reg, tb_reg, bun);
                    mode_next = sr.mode; shc_next = sr.shc; qr_next = sr.qr;
                    again = sr.again; bun = sr.b;
                end
            end
            default: begin
                mode_next = M_IDLE;
                again = 1'b1;
            end
        endcase

        if (again) begin
            tb_next = p;
            if (in_string) begin
                sr = str_byte(data_byte, p, multiline ? M_MSTR : M_SSTR, 1'b0, 2'd0, p, bun);
                mode_next = sr.mode; shc_next = sr.shc; qr_next = sr.qr; bun = sr.b;
            end else if (idst) begin
                mode_next = M_IDENT;
            end else if (dig) begin
                mode_next = M_NUM;
            end else if (data_byte == CH_NL) begin
                if (emit_newlines) bun = add_tok(bun, TK_NEWLINE, p, pe, ERR_NONE);
            end else if (data_byte inside {CH_CR, CH_TAB, CH_SPACE}) begin
                mode_next = M_IDLE;
            end else if (data_byte == CH_QUOTE) begin
                mode_next = M_Q1;
            end else if (data_byte == CH_SLASH) begin
                mode_next = M_SLASH;
            end else if (data_byte == CH_EQUAL) begin
                mode_next = M_EQ;
            end else if (data_byte == CH_LT) begin
                mode_next = M_LT;
            end else if (data_byte == CH_GT) begin
                mode_next = M_GT;
            end else if (data_byte == CH_BAR) begin
                mode_next = M_BAR;
            end else if (data_byte == CH_AMP) begin
                mode_next = M_AMP;
            end else begin
                bun = add_tok(bun, single_kind(data_byte), p, pe, ERR_NONE);
            end
        end

        pos_next = pe;
        fb1 = tb_next + 1'b1;
        if (end_of_input) begin
            case (mode_next)
                M_IDENT: bun = add_tok(bun, TK_IDENT, tb_next, pe, ERR_NONE);
                M_NUM:   bun = add_tok(bun, TK_NUMBER, tb_next, pe, ERR_NONE);
                M_SLASH: bun = add_tok(bun, TK_SLASH, tb_next, pe, ERR_NONE);
                M_EQ:    bun = add_tok(bun, TK_ASSIGN, tb_next, pe, ERR_NONE);
                M_LT:    bun = add_tok(bun, TK_LT, tb_next, pe, ERR_NONE);
                M_GT:    bun = add_tok(bun, TK_GT, tb_next, pe, ERR_NONE);
                M_BAR:   bun = add_tok(bun, TK_BAR, tb_next, pe, ERR_NONE);
                M_AMP:   bun = add_tok(bun, TK_AMP, tb_next, pe, ERR_NONE);
                M_Q1:    bun = add_tok(bun, TK_BEGIN_STR, tb_next, pe, ERR_NONE);
                M_Q2: begin
                    bun = add_tok(bun, TK_BEGIN_STR, tb_next, fb1, ERR_NONE);
                    bun = add_tok(bun, TK_END_STR, fb1, pe, ERR_NONE);
                end
                M_BMSNL: bun = add_tok(bun, TK_BEGIN_MSTR, tb_next, pe, ERR_NONE);
                M_SSTR, M_SESC, M_SDOL, M_MSTR, M_MESC, M_MDOL:
                    bun = add_tok(bun, TK_INVALID, tb_next, pe, ERR_UNTERM);
                default: ;
            endcase
            mode_next = M_IDLE;
            pos_next = '0;
            tb_next = '0;
            shc_next = 1'b0;
            qr_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            pos_reg <= '0;
            tb_reg <= '0;
            shc_reg <= 1'b0;
            qr_reg <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            tb_reg <= tb_next;
            shc_reg <= shc_next;
            qr_reg <= qr_next;
        end
    end

    assign bundle = bun;
    assign push = accept && (bun.cnt != 2'd0);

endmodule
`default_nettype wire

// ===== hdl/slex_queue.sv =====
// Small FIFO of token bundles between the lexer front end and the output stage.
`default_nettype none
module slex_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  slex_pkg::bundle_t      din,
    output logic                   full,
    input  wire logic              rd_en,
    output slex_pkg::bundle_t      dout,
    output logic                   empty
);
    import slex_pkg::*;

    localparam int AW = $clog2(DEPTH);

    bundle_t       mem [DEPTH];
    logic [AW:0]   wr_ptr_reg, rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_ptr_reg[AW-1:0]] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (wr_en) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en) rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    assign dout  = mem[rd_ptr_reg[AW-1:0]];
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg - rd_ptr_reg) == (AW + 1)'(DEPTH);

endmodule
`default_nettype wire

// ===== hdl/slex_back.sv =====
// Output stage: unpacks queued bundles into one token transaction per cycle while ready is high.
`default_nettype none
module slex_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  slex_pkg::bundle_t      head,
    input  wire logic              empty,
    output logic                   pop,
    output logic [5:0]             token_kind,
    output logic [31:0]            start_pos,
    output logic [31:0]            end_pos,
    output logic [1:0]             error_code,
    output logic                   last_of_run,
    output logic                   valid,
    input  wire logic              ready
);
    import slex_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    tok_t       tok_reg;
    logic       last_reg;
    logic       load, last;

    assign load = !empty && (!valid_reg || ready);
    assign last = (idx_reg == head.cnt - 2'd1);
    assign pop = load && last;
    assign idx_next = last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= idx_next;
                valid_reg <= 1'b1;
            end else if (ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= head.tok[idx_reg];
            last_reg <= last;
        end
    end

    assign token_kind  = tok_reg.kind;
    assign start_pos   = tok_reg.start_pos;
    assign end_pos     = tok_reg.end_pos;
    assign error_code  = tok_reg.err;
    assign last_of_run = last_reg;
    assign valid       = valid_reg;

endmodule
`default_nettype wire

// ===== hdl/script_lexer_byte_stream.sv =====
// Top level of the streaming script lexer: config register, front end, queue, output stage.
// Tokens go through the queue and are registered in the output stage before m_valid rises.
// Throughput: one byte per cycle while s_ready is high; tokens leave one per cycle while
// m_ready is high; bytes closing more than one token are absorbed by a four-bundle queue.
// s_ready drops only while that queue is full.
// Reset: synchronous, active low; lexer idle at offset 0, queue empty, emit_newlines 0.
`default_nettype none
module script_lexer_byte_stream #(
    parameter int OFFSET_BITS = slex_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_input,
    input  wire logic        s_in_string,
    input  wire logic        s_multiline,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic [5:0]       m_token_kind,
    output logic [31:0]      m_start_pos,
    output logic [31:0]      m_end_pos,
    output logic [1:0]       m_error_code,
    output logic             m_last_of_run,
    output logic             m_valid,
    input  wire logic        m_ready
);
    import slex_pkg::*;

    logic     emit_nl_reg;
    logic     full, empty, push, pop, accept;
    bundle_t  wr_bundle, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_nl_reg <= 1'b0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            emit_nl_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, emit_nl_reg};

    assign s_ready = !full;
    assign accept = s_valid && s_ready;

    slex_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .end_of_input  (s_end_of_input),
        .in_string     (s_in_string),
        .multiline     (s_multiline),
        .emit_newlines (emit_nl_reg),
        .bundle        (wr_bundle),
        .push          (push)
    );

    slex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .din     (wr_bundle),
        .full    (full),
        .rd_en   (pop),
        .dout    (head),
        .empty   (empty)
    );

    slex_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (m_token_kind),
        .start_pos   (m_start_pos),
        .end_pos     (m_end_pos),
        .error_code  (m_error_code),
        .last_of_run (m_last_of_run),
        .valid       (m_valid),
        .ready       (m_ready)
    );

endmodule
`default_nettype wire

// ===== hdl/slex_checker.sv =====
// Port-level checks for the script lexer, bound to the top level.
`default_nettype none
module slex_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [31:0] prdata,
    input wire logic        pready,
    input wire logic [5:0]  m_token_kind,
    input wire logic [1:0]  m_error_code,
    input wire logic        m_valid,
    input wire logic        m_ready
);

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

    a_prdata_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[31:1] == 31'd0)
        else $error("prdata upper bits set");

    a_reset_idle: assert property (@(posedge aclk) !$past(aresetn) |-> !m_valid)
        else $error("m_valid after reset");

    a_err_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != 2'd0 |-> m_token_kind == 6'd0)
        else $error("error flagged on a valid token kind");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped");

endmodule

bind script_lexer_byte_stream slex_checker u_slex_checker (.*);
`default_nettype wire
